// ===== hw/rtl/rcrs_pkg.sv =====
// shared constants, codes, types and helpers of the reliable channel receive sequencer
`default_nettype none

package rcrs_pkg;

  // reorder store and handle sizing
  localparam int REORDER_WINDOW = 32;
  localparam int HANDLE_WIDTH   = 8;
  localparam int SEQ_W          = 16;
  localparam int SLOT_W         = $clog2(REORDER_WINDOW);
  localparam int SLOT_SUM_W     = SLOT_W + 1;

  // stream payload widths
  localparam int IN_TDATA_W  = ((SEQ_W + HANDLE_WIDTH + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((SEQ_W + HANDLE_WIDTH + 7) / 8) * 8;
  localparam int IN_TUSER_W  = 4;
  localparam int OUT_TUSER_W = 3;

  // seen map organized as rows of bits
  localparam int SEEN_COL_W    = 4;
  localparam int SEEN_ROW_W    = SEQ_W - SEEN_COL_W;
  localparam int SEEN_ROW_BITS = 2 ** SEEN_COL_W;
  localparam int SEEN_ROWS     = 2 ** SEEN_ROW_W;

  // packet types
  localparam logic [1:0] PKT_DATA = 2'd0;

  // channel codes
  localparam logic [1:0] CH_UNREL_UNORD = 2'd0;
  localparam logic [1:0] CH_UNREL_SEQ   = 2'd1;
  localparam logic [1:0] CH_REL_UNORD   = 2'd2;
  localparam logic [1:0] CH_REL_ORD     = 2'd3;

  // result kinds
  localparam logic KIND_ACK     = 1'b0;
  localparam logic KIND_DELIVER = 1'b1;

  // request to the seen map: read a row, or set the bit of the last read
  typedef struct packed {
    logic             rd;
    logic             set;
    logic [SEQ_W-1:0] seq;
  } seen_req_t;

  // wrap-aware half-range compare: a newer than b
  function automatic logic seq_newer(input logic [SEQ_W-1:0] a, input logic [SEQ_W-1:0] b);
    logic [SEQ_W-1:0] d;
    d = a - b;
    seq_newer = ((d != '0) && !d[SEQ_W-1]) ||
                ((d == {1'b1, {(SEQ_W-1){1'b0}}}) && (a > b));
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/reliable_channel_receive_sequencer.sv =====
// top level of the reliable channel receive sequencer: packet headers in, acks and deliveries out
// usage
//   in_* takes one parsed packet header per transfer: in_tuser holds packet type and
//   channel, in_tdata holds sequence number and payload buffer handle
//   out_* gives results: acks for data on reliable channels (always first) and message
//   deliveries; out_tlast marks the final result caused by one header
//   ack and malformed headers cause no result and are taken back to back
// timing
//   a data header is accepted, then looked up against the channel state, then gives one
//   result per cycle while out_tready is high; an in-order packet on the ordered
//   channel that closes a gap also walks the held entries of the reorder store,
//   one per cycle while out_tready is high, up to 34 results in all
//   the lookup state is there for the registered read of the seen map and handle memory
// reset
//   rst_n is synchronous; afterwards the seen map is swept clear, all 4096 rows, with
//   in_tready low; all sequence state and the reorder store start empty
// stalls
//   a result waits in the output register until taken; the last result of a header
//   may wait there while the next header is already accepted and looked up
`default_nettype none

module reliable_channel_receive_sequencer (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // header input channel
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [rcrs_pkg::IN_TDATA_W-1:0]  in_tdata,   // seq_number, payload_handle
  input  wire logic [rcrs_pkg::IN_TUSER_W-1:0]  in_tuser,   // packet_type, channel_id
  // result channel
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic [rcrs_pkg::OUT_TDATA_W-1:0]      out_tdata,  // out_sequence, out_handle
  output logic [rcrs_pkg::OUT_TUSER_W-1:0]      out_tuser,  // result_kind, out_channel
  output logic                                  out_tlast   // last_of_run
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EVAL = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  localparam int W   = rcrs_pkg::REORDER_WINDOW;
  localparam int SW  = rcrs_pkg::SLOT_W;
  localparam int HW  = rcrs_pkg::HANDLE_WIDTH;
  localparam int QW  = rcrs_pkg::SEQ_W;

  // fsm and latched header
  logic [1:0]     state_r, state_nxt;
  logic [1:0]     ch_r, ch_nxt;
  logic [QW-1:0]  seq_r, seq_nxt;
  logic [HW-1:0]  handle_r, handle_nxt;

  // channel state
  logic           seq_flag_r, seq_flag_nxt;
  logic [QW-1:0]  newest_r, newest_nxt;
  logic [QW-1:0]  expected_r, expected_nxt;
  logic [SW-1:0]  head_r, head_nxt;
  logic [W-1:0]   valid_r, valid_nxt;

  // pending results of the current header
  logic           ack_p_r, ack_p_nxt;
  logic           dlv_p_r, dlv_p_nxt;

  // output register
  logic           out_valid_r, out_valid_nxt;
  logic           out_kind_r, out_kind_nxt;
  logic [1:0]     out_ch_r, out_ch_nxt;
  logic [QW-1:0]  out_seq_r, out_seq_nxt;
  logic [HW-1:0]  out_handle_r, out_handle_nxt;
  logic           out_last_r, out_last_nxt;

  // reorder handle memory
  logic [HW-1:0]  hmem [W];
  logic [HW-1:0]  rd_handle_r;
  logic           hold_we;

  // seen map
  rcrs_pkg::seen_req_t seen_req;
  logic           seen_bit;
  logic           seen_busy;

  // lookup helpers
  logic                          in_accept;
  logic                          out_free;
  logic [QW-1:0]                 ord_d;
  logic [rcrs_pkg::SLOT_SUM_W-1:0] slot_sum;
  logic [SW-1:0]                 slot;
  logic [SW-1:0]                 head_inc;
  logic                          deliver;
  logic                          hold;
  logic                          emit_last;

  rcrs_seen_map u_seen (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (seen_req),
    .seen  (seen_bit),
    .busy  (seen_busy)
  );

  assign in_tready = (state_r == S_IDLE) && !seen_busy;
  assign in_accept = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // distance of the packet ahead of the expected ordered sequence and its ring slot
  assign ord_d    = seq_r - expected_r;
  assign slot_sum = {1'b0, head_r} + ord_d[SW:0];
  assign slot     = (slot_sum >= rcrs_pkg::SLOT_SUM_W'(W)) ?
                    SW'(slot_sum - rcrs_pkg::SLOT_SUM_W'(W)) : slot_sum[SW-1:0];
  assign head_inc = (head_r == SW'(W - 1)) ? '0 : head_r + 1'b1;

  // delivery decision per channel
  always_comb begin
    case (ch_r)
      rcrs_pkg::CH_UNREL_UNORD: deliver = 1'b1;
      rcrs_pkg::CH_UNREL_SEQ:   deliver = !seq_flag_r || rcrs_pkg::seq_newer(seq_r, newest_r);
      rcrs_pkg::CH_REL_UNORD:   deliver = !seen_bit;
      rcrs_pkg::CH_REL_ORD:     deliver = (ord_d == '0);
      default:                  deliver = 1'b0;
    endcase
  end

  // future ordered packet inside the window, first copy only
  assign hold = (ch_r == rcrs_pkg::CH_REL_ORD) && (ord_d != '0) &&
                (ord_d <= QW'(W)) && !valid_r[slot];

  assign hold_we = (state_r == S_EVAL) && hold;

  always_comb begin
    state_nxt      = state_r;
    ch_nxt         = ch_r;
    seq_nxt        = seq_r;
    handle_nxt     = handle_r;
    seq_flag_nxt   = seq_flag_r;
    newest_nxt     = newest_r;
    expected_nxt   = expected_r;
    head_nxt       = head_r;
    valid_nxt      = valid_r;
    ack_p_nxt      = ack_p_r;
    dlv_p_nxt      = dlv_p_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_kind_nxt   = out_kind_r;
    out_ch_nxt     = out_ch_r;
    out_seq_nxt    = out_seq_r;
    out_handle_nxt = out_handle_r;
    out_last_nxt   = out_last_r;
    emit_last      = 1'b0;
    seen_req.rd    = in_accept;
    seen_req.set   = 1'b0;
    seen_req.seq   = in_tdata[QW-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          ch_nxt     = in_tuser[3:2];
          seq_nxt    = in_tdata[QW-1:0];
          handle_nxt = in_tdata[QW+HW-1:QW];
          // only data packets do anything
          if (in_tuser[1:0] == rcrs_pkg::PKT_DATA) begin
            state_nxt = S_EVAL;
          end
        end
      end

      S_EVAL: begin
        // reliable channels are acked first
        ack_p_nxt = ch_r[1];
        dlv_p_nxt = deliver;
        case (ch_r)
          rcrs_pkg::CH_UNREL_SEQ: begin
            if (deliver) begin
              seq_flag_nxt = 1'b1;
              newest_nxt   = seq_r;
            end
          end
          rcrs_pkg::CH_REL_UNORD: begin
            seen_req.set = deliver;
          end
          rcrs_pkg::CH_REL_ORD: begin
            if (deliver) begin
              expected_nxt = expected_r + 1'b1;
              head_nxt     = head_inc;
            end
            if (hold) begin
              valid_nxt[slot] = 1'b1;
            end
          end
          default: begin
          end
        endcase
        state_nxt = (ch_r[1] || deliver) ? S_EMIT : S_IDLE;
      end

      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_ch_nxt    = ch_r;
          if (ack_p_r) begin
            out_kind_nxt   = rcrs_pkg::KIND_ACK;
            out_seq_nxt    = seq_r;
            out_handle_nxt = '0;
            emit_last      = !dlv_p_r;
            ack_p_nxt      = 1'b0;
          end else if (dlv_p_r) begin
            out_kind_nxt   = rcrs_pkg::KIND_DELIVER;
            out_seq_nxt    = seq_r;
            out_handle_nxt = handle_r;
            emit_last      = !((ch_r == rcrs_pkg::CH_REL_ORD) && valid_r[head_r]);
            dlv_p_nxt      = 1'b0;
          end else begin
            // drain held entries now next in line
            out_kind_nxt     = rcrs_pkg::KIND_DELIVER;
            out_seq_nxt      = expected_r;
            out_handle_nxt   = rd_handle_r;
            valid_nxt[head_r] = 1'b0;
            expected_nxt     = expected_r + 1'b1;
            head_nxt         = head_inc;
            emit_last        = !valid_r[head_inc];
          end
          out_last_nxt = emit_last;
          if (emit_last) begin
            state_nxt = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      seq_flag_r  <= 1'b0;
      newest_r    <= '0;
      expected_r  <= '0;
      head_r      <= '0;
      valid_r     <= '0;
      ack_p_r     <= 1'b0;
      dlv_p_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      seq_flag_r  <= seq_flag_nxt;
      newest_r    <= newest_nxt;
      expected_r  <= expected_nxt;
      head_r      <= head_nxt;
      valid_r     <= valid_nxt;
      ack_p_r     <= ack_p_nxt;
      dlv_p_r     <= dlv_p_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    ch_r         <= ch_nxt;
    seq_r        <= seq_nxt;
    handle_r     <= handle_nxt;
    out_kind_r   <= out_kind_nxt;
    out_ch_r     <= out_ch_nxt;
    out_seq_r    <= out_seq_nxt;
    out_handle_r <= out_handle_nxt;
    out_last_r   <= out_last_nxt;
  end

  // handle memory, read at the coming head so the data matches head_r in the cycle after
  always_ff @(posedge clk) begin
    if (hold_we) begin
      hmem[slot] <= handle_r;
    end
    rd_handle_r <= hmem[head_nxt];
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = rcrs_pkg::OUT_TDATA_W'({out_handle_r, out_seq_r});
  assign out_tuser  = {out_ch_r, out_kind_r};
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

// ===== hw/rtl/rcrs_seen_map.sv =====
// duplicate filter bitmap for the reliable unordered channel, cleared by a sweep after reset
`default_nettype none

module rcrs_seen_map (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire rcrs_pkg::seen_req_t req,
  output logic                   seen,
  output logic                   busy
);

  logic [rcrs_pkg::SEEN_ROW_BITS-1:0] mem [rcrs_pkg::SEEN_ROWS];

  logic                               clearing_r;
  logic [rcrs_pkg::SEEN_ROW_W-1:0]    clr_cnt_r;
  logic [rcrs_pkg::SEEN_ROW_W-1:0]    addr_r;
  logic [rcrs_pkg::SEEN_COL_W-1:0]    col_r;
  logic [rcrs_pkg::SEEN_ROW_BITS-1:0] row_r;

  // clearing sweep, one row a cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clearing_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (&clr_cnt_r) begin
        clearing_r <= 1'b0;
      end
    end
  end

  // row memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (clearing_r) begin
      mem[clr_cnt_r] <= '0;
    end else if (req.set) begin
      mem[addr_r] <= row_r | (rcrs_pkg::SEEN_ROW_BITS'(1) << col_r);
    end
    if (req.rd) begin
      row_r  <= mem[req.seq[rcrs_pkg::SEQ_W-1:rcrs_pkg::SEEN_COL_W]];
      addr_r <= req.seq[rcrs_pkg::SEQ_W-1:rcrs_pkg::SEEN_COL_W];
      col_r  <= req.seq[rcrs_pkg::SEEN_COL_W-1:0];
    end
  end

  assign seen = row_r[col_r];
  assign busy = clearing_r;

endmodule

`default_nettype wire
